/* src/okvt_pkg.sv */
// okvt_pkg: shared constants, codes and types of the ordered key/value table.
// Used by okvt_ctrl, okvt_dp and ordered_key_value_table_unit; no dependencies.
package okvt_pkg;

   localparam int CAPACITY   = 16;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 32;
   localparam int VAL_W      = 32;
   localparam int RANK_W     = 8;
   localparam int OP_W       = 3;
   localparam int STAT_W     = 3;
   localparam int CMP_W      = (CNT_W > RANK_W) ? CNT_W : RANK_W;
   localparam int REQ_DATA_W = ((KEY_W + VAL_W + RANK_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((KEY_W + VAL_W + CNT_W + 7) / 8) * 8;

   // opcodes
   localparam logic [OP_W-1:0] OP_INSERT = OP_W'(0);
   localparam logic [OP_W-1:0] OP_UPDATE = OP_W'(1);
   localparam logic [OP_W-1:0] OP_UPSERT = OP_W'(2);
   localparam logic [OP_W-1:0] OP_ERASE  = OP_W'(3);
   localparam logic [OP_W-1:0] OP_LOOKUP = OP_W'(4);
   localparam logic [OP_W-1:0] OP_SELECT = OP_W'(5);

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK      = STAT_W'(0);
   localparam logic [STAT_W-1:0] STAT_FULL    = STAT_W'(1);
   localparam logic [STAT_W-1:0] STAT_PRESENT = STAT_W'(2);
   localparam logic [STAT_W-1:0] STAT_ABSENT  = STAT_W'(3);
   localparam logic [STAT_W-1:0] STAT_RANK    = STAT_W'(4);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_HIT,
      S_MISS,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SEL_S_RD,
      S_SEL_S_LD,
      S_SEL_T_RD,
      S_SEL_T_CMP,
      S_SEL_CHECK,
      S_RESULT
   } state_type;

   typedef enum logic [1:0] {RD_IDX, RD_IDX_NEXT, RD_S, RD_T} rd_sel_type;
   typedef enum logic [1:0] {WR_NONE, WR_VALUE, WR_TAIL, WR_SHIFT} wr_mode_type;
   typedef enum logic [1:0] {FOUND_NONE, FOUND_RD_VALUE, FOUND_HOLD} found_type;

   typedef struct packed {
      logic              load_req;
      logic              idx_clr;
      logic              idx_inc;
      logic              s_clr;
      logic              s_inc;
      logic              t_clr;
      logic              t_inc;
      logic              cnt_clr;
      logic              cnt_acc;
      logic              hold_load;
      rd_sel_type        rd_sel;
      wr_mode_type       wr_mode;
      logic              count_inc;
      logic              count_dec;
      logic              pend_load;
      logic [STAT_W-1:0] pend_status;
      found_type         pend_found;
      logic              res_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            match;
      logic            idx_last;
      logic            shift_last;
      logic            full;
      logic            empty;
      logic            rank_bad;
      logic            s_last;
      logic            t_last;
      logic            cnt_hit;
      logic            rsp_free;
   } dp_stat_type;

endpackage

/* src/okvt_ctrl.sv */
// okvt_ctrl: sequencer of the ordered key/value table; drives okvt_dp by commands.
// Depends on okvt_pkg.
module okvt_ctrl
   import okvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type st,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.idx_clr = 1'b1;
            cmd.s_clr   = 1'b1;
            unique case (st.op) inside
               OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP: begin
                  if (st.op == OP_INSERT && st.full) begin
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = STAT_FULL;
                     state_in        = S_RESULT;
                  end else if (st.empty) begin
                     state_in = S_MISS;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
               OP_SELECT: begin
                  if (st.rank_bad) begin
                     cmd.pend_load   = 1'b1;
                     cmd.pend_status = STAT_RANK;
                     state_in        = S_RESULT;
                  end else begin
                     state_in = S_SEL_S_RD;
                  end
               end
               default: begin
                  cmd.pend_load   = 1'b1;
                  cmd.pend_status = STAT_OK;
                  state_in        = S_RESULT;
               end
            endcase
         end
         S_SRCH_RD: begin
            cmd.rd_sel = RD_IDX;
            state_in   = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (st.match) begin
               state_in = S_HIT;
            end else if (st.idx_last) begin
               state_in = S_MISS;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_HIT: begin
            state_in        = S_RESULT;
            cmd.pend_load   = 1'b1;
            cmd.pend_status = STAT_OK;
            unique case (st.op) inside
               OP_INSERT: begin
                  cmd.pend_status = STAT_PRESENT;
               end
               OP_UPDATE, OP_UPSERT: begin
                  cmd.wr_mode = WR_VALUE;
               end
               OP_ERASE: begin
                  if (st.idx_last) begin
                     cmd.count_dec = 1'b1;
                  end else begin
                     cmd.pend_load = 1'b0;
                     state_in      = S_SHIFT_RD;
                  end
               end
               default: begin
                  cmd.pend_found = FOUND_RD_VALUE;
               end
            endcase
         end
         S_MISS: begin
            state_in        = S_RESULT;
            cmd.pend_load   = 1'b1;
            cmd.pend_status = STAT_ABSENT;
            unique case (st.op) inside
               OP_INSERT, OP_UPSERT: begin
                  if (st.full) begin
                     cmd.pend_status = STAT_FULL;
                  end else begin
                     cmd.pend_status = STAT_OK;
                     cmd.wr_mode     = WR_TAIL;
                     cmd.count_inc   = 1'b1;
                  end
               end
               default: begin
                  cmd.pend_status = STAT_ABSENT;
               end
            endcase
         end
         S_SHIFT_RD: begin
            cmd.rd_sel = RD_IDX_NEXT;
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.wr_mode = WR_SHIFT;
            cmd.idx_inc = 1'b1;
            if (st.shift_last) begin
               cmd.count_dec   = 1'b1;
               cmd.pend_load   = 1'b1;
               cmd.pend_status = STAT_OK;
               state_in        = S_RESULT;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SEL_S_RD: begin
            cmd.rd_sel  = RD_S;
            cmd.t_clr   = 1'b1;
            cmd.cnt_clr = 1'b1;
            state_in    = S_SEL_S_LD;
         end
         S_SEL_S_LD: begin
            cmd.hold_load = 1'b1;
            state_in      = S_SEL_T_RD;
         end
         S_SEL_T_RD: begin
            cmd.rd_sel = RD_T;
            state_in   = S_SEL_T_CMP;
         end
         S_SEL_T_CMP: begin
            cmd.cnt_acc = 1'b1;
            if (st.t_last) begin
               state_in = S_SEL_CHECK;
            end else begin
               cmd.t_inc = 1'b1;
               state_in  = S_SEL_T_RD;
            end
         end
         S_SEL_CHECK: begin
            if (st.cnt_hit) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = STAT_OK;
               cmd.pend_found  = FOUND_HOLD;
               state_in        = S_RESULT;
            end else if (st.s_last) begin
               cmd.pend_load   = 1'b1;
               cmd.pend_status = STAT_RANK;
               state_in        = S_RESULT;
            end else begin
               cmd.s_inc = 1'b1;
               state_in  = S_SEL_S_RD;
            end
         end
         S_RESULT: begin
            if (st.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* src/okvt_dp.sv */
// okvt_dp: datapath of the ordered key/value table: key and value stores, index
// counters, compare logic and the result register. Depends on okvt_pkg.
module okvt_dp
   import okvt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STAT_W-1:0]     rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  dp_cmd_type            cmd,
   output dp_stat_type           st
);

   localparam int EXT_W = CNT_W + 1;

   logic [KEY_W-1:0] key_mem [CAPACITY];
   logic [VAL_W-1:0] val_mem [CAPACITY];

   logic [OP_W-1:0]   op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  idx_ff, s_ff, t_ff, cnt_ff;
   logic [KEY_W-1:0]  rd_key_ff, hold_key_ff;
   logic [VAL_W-1:0]  rd_val_ff, hold_val_ff;
   logic [STAT_W-1:0] pend_status_ff, rsp_status_ff;
   logic [KEY_W-1:0]  pend_key_ff, rsp_key_ff;
   logic [VAL_W-1:0]  pend_val_ff, rsp_val_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_valid_ff;

   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [KEY_W-1:0]  wr_key;
   logic [VAL_W-1:0]  wr_val;
   logic              wr_key_en, wr_val_en;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_tuser;
         key_ff  <= req_tdata[KEY_W-1:0];
         val_ff  <= req_tdata[KEY_W+VAL_W-1:KEY_W];
         rank_ff <= req_tdata[KEY_W+VAL_W+RANK_W-1:KEY_W+VAL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // walk counters
   always_ff @(posedge clock) begin
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.s_clr) begin
         s_ff <= '0;
      end else if (cmd.s_inc) begin
         s_ff <= s_ff + IDX_W'(1);
      end
      if (cmd.t_clr) begin
         t_ff <= '0;
      end else if (cmd.t_inc) begin
         t_ff <= t_ff + IDX_W'(1);
      end
      if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_acc && (rd_key_ff < hold_key_ff)) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
      if (cmd.hold_load) begin
         hold_key_ff <= rd_key_ff;
         hold_val_ff <= rd_val_ff;
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:      rd_addr = idx_ff;
         RD_IDX_NEXT: rd_addr = idx_ff + IDX_W'(1);
         RD_S:        rd_addr = s_ff;
         RD_T:        rd_addr = t_ff;
         default:     rd_addr = idx_ff;
      endcase
   end

   always_comb begin
      wr_addr   = idx_ff;
      wr_key    = rd_key_ff;
      wr_val    = rd_val_ff;
      wr_key_en = 1'b0;
      wr_val_en = 1'b0;
      unique case (cmd.wr_mode)
         WR_VALUE: begin
            wr_val    = val_ff;
            wr_val_en = 1'b1;
         end
         WR_TAIL: begin
            wr_addr   = count_ff[IDX_W-1:0];
            wr_key    = key_ff;
            wr_val    = val_ff;
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
         end
         WR_SHIFT: begin
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
         end
         default: begin
            wr_key_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr_val_en) begin
         val_mem[wr_addr] <= wr_val;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   // pending result, then output register
   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_status_ff <= cmd.pend_status;
         case (cmd.pend_found)
            FOUND_RD_VALUE: begin
               pend_key_ff <= '0;
               pend_val_ff <= rd_val_ff;
            end
            FOUND_HOLD: begin
               pend_key_ff <= hold_key_ff;
               pend_val_ff <= hold_val_ff;
            end
            default: begin
               pend_key_ff <= '0;
               pend_val_ff <= '0;
            end
         endcase
      end
      if (cmd.res_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_key_ff    <= pend_key_ff;
         rsp_val_ff    <= pend_val_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_val_ff, rsp_key_ff});

   always_comb begin
      st.op         = op_ff;
      st.match      = (rd_key_ff == key_ff);
      st.idx_last   = (EXT_W'(idx_ff) + EXT_W'(1)) >= EXT_W'(count_ff);
      st.shift_last = (EXT_W'(idx_ff) + EXT_W'(2)) >= EXT_W'(count_ff);
      st.full       = (count_ff == CNT_W'(CAPACITY));
      st.empty      = (count_ff == '0);
      st.rank_bad   = CMP_W'(rank_ff) >= CMP_W'(count_ff);
      st.s_last     = (EXT_W'(s_ff) + EXT_W'(1)) >= EXT_W'(count_ff);
      st.t_last     = (EXT_W'(t_ff) + EXT_W'(1)) >= EXT_W'(count_ff);
      st.cnt_hit    = CMP_W'(cnt_ff) == CMP_W'(rank_ff);
      st.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

/* src/ordered_key_value_table_unit.sv */
// ordered_key_value_table_unit: top level of the ordered key/value table.
// Joins okvt_ctrl and okvt_dp; depends on okvt_pkg.
//
//   channel | dir | tdata (low bit up)                            | tuser
//   req_    | in  | key[31:0] value[63:32] rank[71:64]            | opcode
//   rsp_    | out | found_key[31:0] found_value[63:32]            | status
//           |     | entry_count[68:64], zero fill [71:69]         |
//
// One request at a time. Search-based operations scan the stored entries one by one;
// erase then shifts each later entry down by one slot. Select by rank walks candidate
// slots, for each counting the stored keys below its key; all walks are sequential,
// as the key and value stores have a single read port.
// Reset (synchronous) empties the table; stores are not cleared.
// A new request is taken while the previous result waits on rsp_tready.
module ordered_key_value_table_unit
   import okvt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // key, value, rank
   input  logic [OP_W-1:0]       req_tuser,  // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found_key, found_value, entry_count
   output logic [STAT_W-1:0]     rsp_tuser   // status
);

   dp_cmd_type  cmd;
   dp_stat_type st;

   okvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   okvt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule
